/* src/imdu_pkg.sv */
// shared types, opcodes and width codes for the multiply/divide unit
`default_nettype none
package imdu_pkg;
   localparam logic [2:0] FUNC_MULU  = 3'd0;
   localparam logic [2:0] FUNC_MULS  = 3'd1;
   localparam logic [2:0] FUNC_MULT  = 3'd2;
   localparam logic [2:0] FUNC_DIVU  = 3'd3;
   localparam logic [2:0] FUNC_DIVS  = 3'd4;

   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   localparam int unsigned DATA_W = 64;
   // two quotient bits per divider stage, one register slice per stage
   localparam int unsigned DIV_BITS_PER_STAGE = 2;
   localparam int unsigned DIV_STAGES = DATA_W / DIV_BITS_PER_STAGE;

   typedef struct packed {
      logic [2:0]  func;
      logic [1:0]  width_sel;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
      logic [63:0] dividend_high;
      logic        imm8_extend;
   } req_type;

   typedef struct packed {
      logic [63:0] result_low;
      logic [63:0] result_high;
      logic        carry_flag;
      logic        overflow_flag;
      logic        flags_written;
      logic        divide_error;
   } rsp_type;

   function automatic logic [63:0] width_mask(input logic [1:0] ws);
      logic [63:0] m;
      m = '1;
      case (ws)
         WIDTH_8:  m = 64'h0000_0000_0000_00ff;
         WIDTH_16: m = 64'h0000_0000_0000_ffff;
         WIDTH_32: m = 64'h0000_0000_ffff_ffff;
         default:  m = '1;
      endcase
      return m;
   endfunction

   // value of bit w-1 of v
   function automatic logic top_bit(input logic [63:0] v, input logic [1:0] ws);
      logic b;
      b = v[63];
      case (ws)
         WIDTH_8:  b = v[7];
         WIDTH_16: b = v[15];
         WIDTH_32: b = v[31];
         default:  b = v[63];
      endcase
      return b;
   endfunction

   function automatic logic [63:0] sext(input logic [63:0] v, input logic [1:0] ws);
      logic [63:0] r;
      r = v;
      case (ws)
         WIDTH_8:  r = {{56{v[7]}}, v[7:0]};
         WIDTH_16: r = {{48{v[15]}}, v[15:0]};
         WIDTH_32: r = {{32{v[31]}}, v[31:0]};
         default:  r = v;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

/* src/imdu_if.sv */
// valid/ready channel carrying one request or response item
`default_nettype none
interface imdu_req_if;
   logic              valid;
   logic              ready;
   imdu_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface imdu_rsp_if;
   logic              valid;
   logic              ready;
   imdu_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/integer_mul_div_unit_core.sv */
// Integer multiply/divide unit: x86 mul, imul and div, idiv at 8 to 64 bits.
// Channels: req (sink) takes func, width_sel, operand_a, operand_b,
// dividend_high and imm8_extend; rsp (source) returns result_low,
// result_high, carry_flag, overflow_flag, flags_written and divide_error.
// Every request gives exactly one response, in order.
// Throughput: one transfer per cycle on each side while rsp is not stalled.
// Stages: one that prepares operands, one that fixes signs, the divider's
// 64 quotient bits at two bits per pipeline stage (32 stages), and the
// output register. The multiplier is built from four 32x32 partial products,
// registered, then summed, and the multiply result rides along the divider
// stages to stay in order. Reset (synchronous, active high) clears all
// valid bits; payload is not cleared. When rsp is stalled the whole
// pipeline holds: req.ready is low only while the output register is full
// and not being taken, so an item never gets lost or repeated.
`default_nettype none
module integer_mul_div_unit_core (
   input  wire logic  clock,
   input  wire logic  reset,
   imdu_req_if.sink   req,
   imdu_rsp_if.source rsp
);
   localparam int unsigned NS = imdu_pkg::DIV_STAGES;

   // per-item control carried along the pipe
   typedef struct packed {
      logic [2:0]  func;
      logic [1:0]  ws;
      logic        is_mul;
      logic        nn;      // dividend negative
      logic        qn;      // quotient negative
      logic        de;      // early divide error
      logic [63:0] dm;      // divisor magnitude
      logic [63:0] mul_lo;
      logic [63:0] mul_hi;
      logic        cf;
   } ctl_type;

   logic advance;
   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // ---------------- stage 0: operand prep + partial products
   logic        s0_v_ff;
   ctl_type     s0_c_ff, s0_c_in;
   logic [63:0] s0_rem_ff, s0_rem_in, s0_num_ff, s0_num_in;
   logic [63:0] s0_sa_ff, s0_sb_ff, s0_sa_in, s0_sb_in;
   logic [63:0] pp0_ff, pp1_ff, pp2_ff, pp3_ff;
   logic [63:0] pp0_in, pp1_in, pp2_in, pp3_in;

   always_comb begin
      logic [63:0] m, a, b, dh, sa, sb, ua, ub, nh, nl, dm;
      logic        nn, dn, signed_mul;
      m  = imdu_pkg::width_mask(req.payload.width_sel);
      a  = req.payload.operand_a & m;
      b  = req.payload.operand_b & m;
      dh = req.payload.dividend_high & m;
      if (req.payload.imm8_extend)
         b = {{56{req.payload.operand_b[7]}}, req.payload.operand_b[7:0]} & m;
      signed_mul = (req.payload.func == imdu_pkg::FUNC_MULS) ||
                   (req.payload.func == imdu_pkg::FUNC_MULT);
      sa = signed_mul ? imdu_pkg::sext(a, req.payload.width_sel) : a;
      sb = signed_mul ? imdu_pkg::sext(b, req.payload.width_sel) : b;
      // unsigned products of the 64-bit patterns, corrected later for sign
      ua = sa;
      ub = sb;
      pp0_in = ua[31:0]  * ub[31:0];
      pp1_in = ua[31:0]  * ub[63:32];
      pp2_in = ua[63:32] * ub[31:0];
      pp3_in = ua[63:32] * ub[63:32];
      s0_sa_in = sa;
      s0_sb_in = sb;

      nn = 1'b0;
      dn = 1'b0;
      nh = dh;
      nl = a;
      dm = b;
      if (req.payload.func == imdu_pkg::FUNC_DIVS) begin
         nn = imdu_pkg::top_bit(dh, req.payload.width_sel);
         dn = imdu_pkg::top_bit(b, req.payload.width_sel);
         if (nn) begin
            nl = (64'd0 - a) & m;
            nh = (~dh + {63'd0, (a == 64'd0)}) & m;
         end
         if (dn)
            dm = (64'd0 - b) & m;
      end
      s0_c_in        = '0;
      s0_c_in.func   = req.payload.func;
      s0_c_in.ws     = req.payload.width_sel;
      s0_c_in.is_mul = (req.payload.func <= imdu_pkg::FUNC_MULT);
      s0_c_in.nn     = nn;
      s0_c_in.qn     = nn ^ dn;
      s0_c_in.de     = (b == 64'd0) || (nh >= dm);
      s0_c_in.dm     = dm;
      s0_rem_in      = nh;
      // left-align the low dividend so the next bit always sits at bit 63
      case (req.payload.width_sel)
         imdu_pkg::WIDTH_8:  s0_num_in = {nl[7:0], 56'd0};
         imdu_pkg::WIDTH_16: s0_num_in = {nl[15:0], 48'd0};
         imdu_pkg::WIDTH_32: s0_num_in = {nl[31:0], 32'd0};
         default:            s0_num_in = nl;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (advance) begin
         s0_v_ff <= req.valid;
      end
      if (advance) begin
         s0_c_ff   <= s0_c_in;
         s0_rem_ff <= s0_rem_in;
         s0_num_ff <= s0_num_in;
         s0_sa_ff  <= s0_sa_in;
         s0_sb_ff  <= s0_sb_in;
         pp0_ff    <= pp0_in;
         pp1_ff    <= pp1_in;
         pp2_ff    <= pp2_in;
         pp3_ff    <= pp3_in;
      end
   end

   // ---------------- stage 1: product sum, sign fix and flags
   ctl_type s1_c_in;
   always_comb begin
      logic [65:0]  mid;
      logic [63:0]  pl, ph, m, lo, hi, ext;
      logic [1:0]   ws;
      mid = {34'd0, pp0_ff[63:32]} + {34'd0, pp1_ff[31:0]} + {34'd0, pp2_ff[31:0]};
      pl  = {mid[31:0], pp0_ff[31:0]};
      ph  = pp3_ff + {32'd0, pp1_ff[63:32]} + {32'd0, pp2_ff[63:32]} +
            {30'd0, mid[65:32]};
      if (s0_c_ff.func != imdu_pkg::FUNC_MULU) begin
         if (s0_sa_ff[63]) ph = ph - s0_sb_ff;
         if (s0_sb_ff[63]) ph = ph - s0_sa_ff;
      end
      ws = s0_c_ff.ws;
      m  = imdu_pkg::width_mask(ws);
      lo = pl & m;
      case (ws)
         imdu_pkg::WIDTH_8:  hi = {56'd0, pl[15:8]};
         imdu_pkg::WIDTH_16: hi = {48'd0, pl[31:16]};
         imdu_pkg::WIDTH_32: hi = {32'd0, pl[63:32]};
         default:            hi = ph;
      endcase
      ext = imdu_pkg::top_bit(lo, ws) ? m : 64'd0;
      s1_c_in = s0_c_ff;
      s1_c_in.cf = (s0_c_ff.func == imdu_pkg::FUNC_MULU) ? (hi != 64'd0) : (hi != ext);
      s1_c_in.mul_lo = lo;
      s1_c_in.mul_hi = (s0_c_ff.func == imdu_pkg::FUNC_MULT) ? 64'd0 : hi;
   end

   // ---------------- divider stages: restoring, two bits per stage
   logic          dv_v_ff   [NS+1];
   ctl_type       dv_c_ff   [NS+1];
   logic [63:0]   dv_rem_ff [NS+1];
   logic [63:0]   dv_num_ff [NS+1];
   logic [63:0]   dv_quo_ff [NS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (advance) begin
         dv_v_ff[0] <= s0_v_ff;
      end
      if (advance) begin
         dv_c_ff[0]   <= s1_c_in;
         dv_rem_ff[0] <= s0_rem_ff;
         dv_num_ff[0] <= s0_num_ff;
         dv_quo_ff[0] <= '0;
      end
   end

   for (genvar g = 0; g < NS; g++) begin : g_div
      logic [63:0] rem_in, num_in, quo_in;
      always_comb begin
         logic [63:0] m, r, d, q, n;
         logic        carry;
         m = imdu_pkg::width_mask(dv_c_ff[g].ws);
         d = dv_c_ff[g].dm;
         r = dv_rem_ff[g];
         n = dv_num_ff[g];
         q = dv_quo_ff[g];
         for (int k = 0; k < imdu_pkg::DIV_BITS_PER_STAGE; k++) begin
            carry = imdu_pkg::top_bit(r, dv_c_ff[g].ws);
            r = ({r[62:0], n[63]}) & m;
            n = {n[62:0], 1'b0};
            q = {q[62:0], 1'b0};
            if (carry || r >= d) begin
               r = (r - d) & m;
               q[0] = 1'b1;
            end
         end
         rem_in = r;
         num_in = n;
         quo_in = q;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[g+1] <= 1'b0;
         end else if (advance) begin
            dv_v_ff[g+1] <= dv_v_ff[g];
         end
         if (advance) begin
            dv_c_ff[g+1]   <= dv_c_ff[g];
            dv_rem_ff[g+1] <= rem_in;
            dv_num_ff[g+1] <= num_in;
            dv_quo_ff[g+1] <= quo_in;
         end
      end
   end

   // ---------------- final: signs and result
   // narrower widths finish early; later stages keep shifting, so the result
   // of a width is captured at the stage where its quotient completed and
   // travels on as side data
   logic [63:0] sq8_ff  [NS+1];
   logic [63:0] sr8_ff  [NS+1];
   always_ff @(posedge clock) begin
      if (advance) begin
         sq8_ff[0] <= '0;
         sr8_ff[0] <= '0;
      end
   end
   for (genvar g = 0; g < NS; g++) begin : g_side
      logic [63:0] q_n, r_n;
      always_comb begin
         q_n = sq8_ff[g];
         r_n = sr8_ff[g];
         if ((g == 3 && dv_c_ff[g].ws == imdu_pkg::WIDTH_8) ||
             (g == 7 && dv_c_ff[g].ws == imdu_pkg::WIDTH_16) ||
             (g == 15 && dv_c_ff[g].ws == imdu_pkg::WIDTH_32) ||
             (g == NS - 1 && dv_c_ff[g].ws == imdu_pkg::WIDTH_64)) begin
            q_n = g_div[g].quo_in;
            r_n = g_div[g].rem_in;
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            sq8_ff[g+1] <= q_n;
            sr8_ff[g+1] <= r_n;
         end
      end
   end

   imdu_pkg::rsp_type out_in, out_ff;
   logic              out_v_ff;
   always_comb begin
      logic [63:0] m, q, r, lim;
      logic        bad;
      ctl_type     c;
      c   = dv_c_ff[NS];
      m   = imdu_pkg::width_mask(c.ws);
      q   = sq8_ff[NS] & m;
      r   = sr8_ff[NS] & m;
      lim = (m >> 1) + 64'd1;
      bad = 1'b0;
      out_in = '0;
      if (c.is_mul) begin
         out_in.result_low    = c.mul_lo;
         out_in.result_high   = c.mul_hi;
         out_in.carry_flag    = c.cf;
         out_in.overflow_flag = c.cf;
         out_in.flags_written = 1'b1;
      end else if (c.func == imdu_pkg::FUNC_DIVU) begin
         out_in.divide_error = c.de;
         if (!c.de) begin
            out_in.result_low  = q;
            out_in.result_high = r;
         end
      end else if (c.func == imdu_pkg::FUNC_DIVS) begin
         bad = c.de || (c.qn ? (q > lim) : (q >= lim));
         out_in.divide_error = bad;
         if (!bad) begin
            out_in.result_low  = c.qn ? ((64'd0 - q) & m) : q;
            out_in.result_high = c.nn ? ((64'd0 - r) & m) : r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (advance) begin
         out_v_ff <= dv_v_ff[NS];
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid   = out_v_ff;
   assign rsp.payload = out_ff;

   // a stalled response must hold its contents
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(out_ff))
      else $error("response changed while stalled");
   // flags only for multiplies
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.payload.flags_written |-> !rsp.payload.carry_flag)
      else $error("carry set on divide");
   // a divide error clears both results
   a_de: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.divide_error |->
      rsp.payload.result_low == 64'd0 && rsp.payload.result_high == 64'd0)
      else $error("results not cleared on divide error");
endmodule
`default_nettype wire

/* bench/integer_mul_div_unit_core_tb.sv */
// testbench for the integer multiply/divide unit: random and directed operations checked in order
`timescale 1ns / 1ps
module integer_mul_div_unit_core_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;

   imdu_req_if req_ch ();
   imdu_rsp_if rsp_ch ();

   integer_mul_div_unit_core uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always #5 clock = ~clock;

   imdu_pkg::req_type pending_ops[$];
   imdu_pkg::rsp_type expected_results[$];
   int mismatch_count = 0;
   bit quiet_stretch = 1'b0;
   bit req_taken = 1'b0;

   function automatic logic [63:0] wmask(logic [1:0] ws);
      case (ws)
         imdu_pkg::WIDTH_8:  return 64'hff;
         imdu_pkg::WIDTH_16: return 64'hffff;
         imdu_pkg::WIDTH_32: return 64'hffff_ffff;
         default:            return '1;
      endcase
   endfunction

   function automatic int wbits(logic [1:0] ws);
      return 8 << ws;
   endfunction

   function automatic logic signed [127:0] sx(logic [63:0] v, int w);
      logic [127:0] t;
      t = 128'(v) << (128 - w);
      return $signed(t) >>> (128 - w);
   endfunction

   // compute the expected response of one operation
   function automatic imdu_pkg::rsp_type compute_result(imdu_pkg::req_type op);
      imdu_pkg::rsp_type r;
      logic [63:0] m, a, b, dh;
      int w;
      logic [127:0] prod, num, q, rm, lim;
      logic signed [127:0] sa, sb;
      logic nn, dn;
      m = wmask(op.width_sel);
      w = wbits(op.width_sel);
      a = op.operand_a & m;
      b = op.operand_b & m;
      dh = op.dividend_high & m;
      r = '0;
      if (op.imm8_extend) b = {{56{op.operand_b[7]}}, op.operand_b[7:0]} & m;
      case (op.func)
         imdu_pkg::FUNC_MULU, imdu_pkg::FUNC_MULS, imdu_pkg::FUNC_MULT: begin
            r.flags_written = 1'b1;
            if (op.func == imdu_pkg::FUNC_MULU) begin
               prod = 128'(a) * 128'(b);
            end else begin
               sa = sx(a, w);
               sb = sx(b, w);
               prod = sa * sb;
            end
            r.result_low = prod[63:0] & m;
            r.result_high = (w == 64) ? prod[127:64] : (64'(prod >> w) & m);
            if (op.func == imdu_pkg::FUNC_MULU)
               r.carry_flag = (r.result_high != 0);
            else
               r.carry_flag = (r.result_high != (r.result_low[w-1] ? m : 64'd0));
            if (op.func == imdu_pkg::FUNC_MULT) r.result_high = '0;
            r.overflow_flag = r.carry_flag;
         end
         imdu_pkg::FUNC_DIVU: begin
            num = (128'(dh) << w) | 128'(a);
            if (b == 0 || dh >= b) begin
               r.divide_error = 1'b1;
            end else begin
               r.result_low = 64'(num / 128'(b));
               r.result_high = 64'(num % 128'(b));
            end
         end
         imdu_pkg::FUNC_DIVS: begin
            nn = dh[w-1];
            dn = b[w-1];
            num = (128'(dh) << w) | 128'(a);
            if (nn) num = ((128'd1 << (2 * w)) - num);
            num = num & ((128'd1 << (2 * w)) - 1);
            if (dn) b = (64'd0 - b) & m;
            lim = 128'd1 << (w - 1);
            if (b == 0) begin
               r.divide_error = 1'b1;
            end else begin
               q = num / 128'(b);
               rm = num % 128'(b);
               if ((nn != dn) ? (q > lim) : (q >= lim)) begin
                  r.divide_error = 1'b1;
               end else begin
                  r.result_low = (nn != dn) ? ((64'd0 - 64'(q)) & m) : 64'(q);
                  r.result_high = nn ? ((64'd0 - 64'(rm)) & m) : 64'(rm);
               end
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      case ($urandom_range(0, 7))
         0: v = '0;
         1: v = '1;
         2: v = 64'h8000_0000_0000_0000 >> ($urandom_range(0, 3) * 8 + 32 * $urandom_range(0, 1));
         3: v = 64'($urandom_range(0, 5));
         default: ;
      endcase
      return v;
   endfunction

   task automatic add_op(logic [2:0] f, logic [1:0] ws, logic [63:0] a, logic [63:0] b,
                         logic [63:0] dh, logic ie);
      imdu_pkg::req_type op;
      op.func = f;
      op.width_sel = ws;
      op.operand_a = a;
      op.operand_b = b;
      op.dividend_high = dh;
      op.imm8_extend = ie;
      pending_ops.push_back(op);
   endtask

   // driver: one transfer per accepted edge, changes at falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         // previous transfer (if any) was consumed at the last rising edge
         if (pending_ops.size() != 0 && (quiet_stretch || $urandom_range(0, 99) >= 11)) begin
            req_ch.payload <= pending_ops.pop_front();
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      rsp_ch.ready <= quiet_stretch || $urandom_range(0, 99) >= 11;
   end

   // track accepted transfers at the rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready)
         expected_results.push_back(compute_result(req_ch.payload));
   end

   always @(posedge clock) begin
      imdu_pkg::rsp_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %h", rsp_ch.payload);
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_ch.payload !== exp_r) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: lo %h/%h hi %h/%h cf %b/%b of %b/%b fw %b/%b de %b/%b",
                     exp_r.result_low, rsp_ch.payload.result_low,
                     exp_r.result_high, rsp_ch.payload.result_high,
                     exp_r.carry_flag, rsp_ch.payload.carry_flag,
                     exp_r.overflow_flag, rsp_ch.payload.overflow_flag,
                     exp_r.flags_written, rsp_ch.payload.flags_written,
                     exp_r.divide_error, rsp_ch.payload.divide_error);
            end
         end
      end
   end

   initial begin
      int n;
      logic [2:0] f;
      logic [1:0] ws;
      logic [63:0] m, a, b, dh;
      // directed corners
      add_op(imdu_pkg::FUNC_MULU, imdu_pkg::WIDTH_64, '1, '1, '0, 1'b0);
      add_op(imdu_pkg::FUNC_MULU, imdu_pkg::WIDTH_8, 64'hff, 64'h01, '1, 1'b0);
      add_op(imdu_pkg::FUNC_MULS, imdu_pkg::WIDTH_8, 64'h80, 64'h80, '0, 1'b0);
      add_op(imdu_pkg::FUNC_MULS, imdu_pkg::WIDTH_64, 64'h8000_0000_0000_0000, '1, '0, 1'b0);
      add_op(imdu_pkg::FUNC_MULS, imdu_pkg::WIDTH_16, 64'h7fff, 64'h7fff, '0, 1'b0);
      add_op(imdu_pkg::FUNC_MULT, imdu_pkg::WIDTH_32, 64'h1234_5678, 64'hfe, '0, 1'b1);
      add_op(imdu_pkg::FUNC_MULT, imdu_pkg::WIDTH_64, '1, 64'h80, '0, 1'b1);
      add_op(imdu_pkg::FUNC_DIVU, imdu_pkg::WIDTH_32, 64'd10, '0, '0, 1'b0);
      add_op(imdu_pkg::FUNC_DIVU, imdu_pkg::WIDTH_8, 64'hff, 64'h10, 64'h10, 1'b0);
      add_op(imdu_pkg::FUNC_DIVU, imdu_pkg::WIDTH_64, '1, '1, 64'hffff_ffff_ffff_fffe, 1'b0);
      add_op(imdu_pkg::FUNC_DIVU, imdu_pkg::WIDTH_16, 64'h1, 64'hff, 64'h0, 1'b1);
      add_op(imdu_pkg::FUNC_DIVS, imdu_pkg::WIDTH_8, 64'h80, 64'hff, 64'hff, 1'b0);
      add_op(imdu_pkg::FUNC_DIVS, imdu_pkg::WIDTH_8, 64'h80, 64'h01, 64'hff, 1'b0);
      add_op(imdu_pkg::FUNC_DIVS, imdu_pkg::WIDTH_8, 64'h80, 64'hff, 64'h00, 1'b0);
      add_op(imdu_pkg::FUNC_DIVS, imdu_pkg::WIDTH_64, '0, 64'h8000_0000_0000_0000, '1, 1'b0);
      add_op(imdu_pkg::FUNC_DIVS, imdu_pkg::WIDTH_32, 64'hffff_fff9, 64'd2, 64'hffff_ffff,
             1'b0);
      add_op(imdu_pkg::FUNC_DIVS, imdu_pkg::WIDTH_16, 64'h0, 64'h0, 64'h0, 1'b0);
      add_op(imdu_pkg::FUNC_DIVS, imdu_pkg::WIDTH_16, 64'h7, 64'hfd, 64'h0, 1'b1);
      add_op(3'd5, imdu_pkg::WIDTH_64, '1, '1, '1, 1'b1);
      add_op(3'd6, imdu_pkg::WIDTH_8, '0, '0, '0, 1'b0);
      add_op(3'd7, imdu_pkg::WIDTH_32, 64'h55, 64'haa, 64'h1, 1'b0);
      for (n = 0; n < 1350; n++) begin
         f = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
         ws = 2'($urandom_range(0, 3));
         m = wmask(ws);
         a = rand64();
         b = rand64();
         dh = rand64();
         // mostly keep divides in range so quotients come out
         if ((f == imdu_pkg::FUNC_DIVU || f == imdu_pkg::FUNC_DIVS) &&
             $urandom_range(0, 3) != 0) begin
            if (f == imdu_pkg::FUNC_DIVU) begin
               if ((b & m) == 0) b = b | 64'd1;
               dh = (dh & m) % (b & m);
            end else begin
               dh = $urandom_range(0, 1) ? '0 : '1;
               if ($urandom_range(0, 1)) a = a >> ($urandom_range(1, 8) << ws);
            end
         end
         add_op(f, ws, a, b, dh, $urandom_range(0, 7) == 0);
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_ops.size() == 350);
      quiet_stretch = 1'b1;
      wait (pending_ops.size() == 150);
      quiet_stretch = 1'b0;
      wait (pending_ops.size() == 0);
      @(posedge clock);
      while (req_ch.valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule
